/* hdl/efws_pkg.sv */
// package for the earliest free worker scheduler
// holds shared types, widths and constants; no dependencies
`default_nettype none

package efws_pkg;

   // field widths fixed by the interface
   localparam int TIME_W = 32;
   localparam int DUR_W  = 24;
   localparam int CFG_W  = 5;
   localparam int WID_W  = 4;

   // workers_in_use value after reset
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   // saturation value for times
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_UPDATE
   } efws_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic start;
      logic issue;
      logic commit;
   } efws_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic last_issue;
      logic out_free;
   } efws_status_type;

endpackage

`default_nettype wire

/* hdl/efws_ram.sv */
// generic single write port, single read port ram with registered read
// no package dependency
`default_nettype none

module efws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/efws_ctrl.sv */
// controller state machine: accept, scan of worker free times, update
// depends on efws_pkg
`default_nettype none

module efws_ctrl
   import efws_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire efws_status_type status,
   output efws_cmd_type         cmd
);

   efws_state_type state_ff;
   efws_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.last_issue) state_in = ST_LAST;
         end
         ST_LAST: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         ST_LAST: begin
         end
         ST_UPDATE: begin
            cmd.commit = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/efws_dp.sv */
// datapath: config register, free time ram with valid flags, min search,
// saturating finish, makespan and result register
// depends on efws_pkg and efws_ram
`default_nettype none

module efws_dp
   import efws_pkg::*;
#(
   parameter int MAX_WORKERS = 16,
   localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire efws_cmd_type      cmd,
   output efws_status_type        status,
   input  wire logic              csr_write_enable,
   input  wire logic [CFG_W-1:0]  csr_write_data,
   input  wire logic [DUR_W-1:0]  req_task_duration,
   input  wire logic              req_new_batch,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [WID_W-1:0]       rsp_assigned_worker,
   output logic [TIME_W-1:0]      rsp_start_time,
   output logic [TIME_W-1:0]      rsp_finish_time,
   output logic [TIME_W-1:0]      rsp_makespan
);

   localparam logic [8:0] MAX_W9 = 9'(MAX_WORKERS);

   logic [CFG_W-1:0]       wiu_ff;
   logic [DUR_W-1:0]       dur_ff;
   logic [IDX_W-1:0]       last_idx_ff;
   logic [IDX_W-1:0]       last_idx_in;
   logic [IDX_W-1:0]       rd_addr_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   rd_pending_ff;
   logic                   rd_valid_ff;
   logic [MAX_WORKERS-1:0] valid_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [TIME_W-1:0]      min_time_ff;
   logic [TIME_W-1:0]      makespan_ff;
   logic [TIME_W-1:0]      ram_rd_data;
   logic [TIME_W-1:0]      cur_time;
   logic [TIME_W:0]        sum_full;
   logic [TIME_W-1:0]      finish;
   logic [TIME_W-1:0]      makespan_in;
   logic [8:0]             wiu9;
   logic [IDX_W+WID_W-1:0] best_ext;
   logic                   rsp_valid_ff;
   logic [WID_W-1:0]       rsp_worker_ff;
   logic [TIME_W-1:0]      rsp_start_ff;
   logic [TIME_W-1:0]      rsp_finish_ff;
   logic [TIME_W-1:0]      rsp_makespan_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         wiu_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         wiu_ff <= csr_write_data;
      end
   end

   // last worker index from clamped worker count
   assign wiu9 = {4'b0, wiu_ff};
   always_comb begin
      if (wiu9 == 9'd0) begin
         last_idx_in = '0;
      end else if (wiu9 > MAX_W9) begin
         last_idx_in = IDX_W'(MAX_W9 - 9'd1);
      end else begin
         last_idx_in = IDX_W'(wiu9 - 9'd1);
      end
   end

   // item capture and scan address counter
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dur_ff      <= req_task_duration;
         last_idx_ff <= last_idx_in;
         rd_addr_ff  <= '0;
      end else if (cmd.issue) begin
         rd_addr_ff  <= IDX_W'(rd_addr_ff + 1'b1);
      end
   end

   assign status.last_issue = (rd_addr_ff == last_idx_ff);

   // read pipeline tag
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pending_ff <= 1'b0;
      end else begin
         rd_pending_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_idx_ff   <= rd_addr_ff;
         rd_valid_ff <= valid_ff[rd_addr_ff];
      end
   end

   // free time store
   efws_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_WORKERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (best_idx_ff),
      .wr_data (finish),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   // entries not written since batch clear read as zero
   assign cur_time = rd_valid_ff ? ram_rd_data : '0;

   // running minimum, strict less keeps lowest index on ties
   always_ff @(posedge clock) begin
      if (rd_pending_ff) begin
         if ((rd_idx_ff == '0) || (cur_time < min_time_ff)) begin
            best_idx_ff <= rd_idx_ff;
            min_time_ff <= cur_time;
         end
      end
   end

   // saturating finish time and makespan
   assign sum_full    = {1'b0, min_time_ff} + {{(TIME_W-DUR_W+1){1'b0}}, dur_ff};
   assign finish      = sum_full[TIME_W] ? TIME_MAX : sum_full[TIME_W-1:0];
   assign makespan_in = (finish > makespan_ff) ? finish : makespan_ff;

   // valid flags and makespan, cleared on new batch
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         makespan_ff <= '0;
      end else if (cmd.start && req_new_batch) begin
         valid_ff    <= '0;
         makespan_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[best_idx_ff] <= 1'b1;
         makespan_ff           <= makespan_in;
      end
   end

   // result register
   assign best_ext        = {{WID_W{1'b0}}, best_idx_ff};
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_worker_ff   <= best_ext[WID_W-1:0];
         rsp_start_ff    <= min_time_ff;
         rsp_finish_ff   <= finish;
         rsp_makespan_ff <= makespan_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_assigned_worker = rsp_worker_ff;
   assign rsp_start_time      = rsp_start_ff;
   assign rsp_finish_time     = rsp_finish_ff;
   assign rsp_makespan        = rsp_makespan_ff;

endmodule

`default_nettype wire

/* hdl/earliest_free_worker_scheduler_unit.sv */
// earliest free worker scheduler, top level; depends on efws_pkg, efws_ctrl, efws_dp
// a request beat is accepted only while idle; its result beat follows a scan of
//   the n active workers (workers_in_use clamped to 1..MAX_WORKERS), and no new
//   request beat is accepted until that result is committed; the free time ram is scanned
//   one worker per cycle through its single read port
// reset: synchronous, clears all free times, the makespan and sets workers_in_use to 16
`default_nettype none

module earliest_free_worker_scheduler_unit
   import efws_pkg::*;
#(
   parameter int MAX_WORKERS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [CFG_W-1:0]  csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [DUR_W-1:0]  req_task_duration,
   input  wire logic              req_new_batch,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [WID_W-1:0]       rsp_assigned_worker,
   output logic [TIME_W-1:0]      rsp_start_time,
   output logic [TIME_W-1:0]      rsp_finish_time,
   output logic [TIME_W-1:0]      rsp_makespan
);

   efws_cmd_type    cmd;
   efws_status_type status;

   // controller
   efws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   efws_dp #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_task_duration   (req_task_duration),
      .req_new_batch       (req_new_batch),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_assigned_worker (rsp_assigned_worker),
      .rsp_start_time      (rsp_start_time),
      .rsp_finish_time     (rsp_finish_time),
      .rsp_makespan        (rsp_makespan)
   );

endmodule

`default_nettype wire

/* hdl/efws_checker.sv */
// port level checker for the scheduler, bound to the top level
// depends on efws_pkg
`default_nettype none

module efws_checker
   import efws_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [WID_W-1:0]  rsp_assigned_worker,
   input wire logic [TIME_W-1:0] rsp_start_time,
   input wire logic [TIME_W-1:0] rsp_finish_time,
   input wire logic [TIME_W-1:0] rsp_makespan
);

   // idle after reset: ready for a beat, no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("not idle after reset");

   // one item in flight: an accepted beat closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while an item is in flight");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_assigned_worker)
         && $stable(rsp_start_time) && $stable(rsp_finish_time)
         && $stable(rsp_makespan)))
      else $error("stalled result beat changed");

   // finish never before start
   a_finish_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_finish_time >= rsp_start_time))
      else $error("finish before start");

   // makespan covers this finish
   a_makespan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_makespan >= rsp_finish_time))
      else $error("makespan below finish time");

endmodule

bind earliest_free_worker_scheduler_unit efws_checker u_efws_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_assigned_worker (rsp_assigned_worker),
   .rsp_start_time      (rsp_start_time),
   .rsp_finish_time     (rsp_finish_time),
   .rsp_makespan        (rsp_makespan)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench for earliest_free_worker_scheduler_unit: directed table then random beats
// keeps its own copy of the worker free times and makespan; depends on efws_pkg
module testbench
   import efws_pkg::*;
();

   localparam int MAX_WORKERS = 16;
   localparam int IDLE_LIMIT  = 2000;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 25;

   // one scheduling decision
   typedef struct packed {
      logic [WID_W-1:0]  worker;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] finish;
      logic [TIME_W-1:0] makespan;
   } assignment_type;

   typedef enum logic {ROW_ITEM, ROW_SETTING} row_kind_type;

   // directed row: a task beat, or a new workers_in_use value
   typedef struct packed {
      row_kind_type      kind;
      logic [CFG_W-1:0]  setting;
      logic [DUR_W-1:0]  duration;
      logic              new_batch;
      logic              typed;
      assignment_type    result;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      // right after reset, zero length task
      '{ROW_ITEM,    5'd0,  24'd0,       1'b0, 1'b1, '{4'd0, 32'd0, 32'd0, 32'd0}},
      // longest task on a fresh batch
      '{ROW_ITEM,    5'd0,  24'hFFFFFF,  1'b1, 1'b1,
        '{4'd0, 32'd0, 32'h00FFFFFF, 32'h00FFFFFF}},
      '{ROW_ITEM,    5'd0,  24'd7,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd3,       1'b0, 1'b0, '0},
      '{ROW_SETTING, 5'd3,  24'd0,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd1,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd2,       1'b0, 1'b0, '0},
      // zero workers behaves as one
      '{ROW_SETTING, 5'd0,  24'd0,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd10,      1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd20,      1'b1, 1'b1, '{4'd0, 32'd0, 32'd20, 32'd20}},
      // counts above the worker array are clamped
      '{ROW_SETTING, 5'd31, 24'd0,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd5,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd5,       1'b0, 1'b0, '0},
      '{ROW_SETTING, 5'd17, 24'd0,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd1,       1'b0, 1'b0, '0},
      // shrink the pool mid batch, then let the workers rejoin
      '{ROW_SETTING, 5'd2,  24'd0,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd100,     1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd100,     1'b0, 1'b0, '0},
      '{ROW_SETTING, 5'd16, 24'd0,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd1,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd1,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'hAAAAAA,  1'b1, 1'b1,
        '{4'd0, 32'd0, 32'h00AAAAAA, 32'h00AAAAAA}},
      '{ROW_ITEM,    5'd0,  24'h555555,  1'b0, 1'b0, '0},
      // single worker
      '{ROW_SETTING, 5'd1,  24'd0,       1'b0, 1'b0, '0},
      '{ROW_ITEM,    5'd0,  24'd0,       1'b1, 1'b1, '{4'd0, 32'd0, 32'd0, 32'd0}},
      '{ROW_ITEM,    5'd0,  24'hFFFFFF,  1'b0, 1'b1,
        '{4'd0, 32'd0, 32'h00FFFFFF, 32'h00FFFFFF}}
   };

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [CFG_W-1:0]  csr_write_data;
   logic              req_valid;
   logic              req_stall;
   logic [DUR_W-1:0]  req_task_duration;
   logic              req_new_batch;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [WID_W-1:0]  rsp_assigned_worker;
   logic [TIME_W-1:0] rsp_start_time;
   logic [TIME_W-1:0] rsp_finish_time;
   logic [TIME_W-1:0] rsp_makespan;

   // scheduler shadow state
   logic [TIME_W-1:0] worker_free_at [MAX_WORKERS];
   logic [TIME_W-1:0] batch_span;
   logic [CFG_W-1:0]  pool_setting;

   assignment_type pending_assignments [$];
   assignment_type oldest;

   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_requests;
   int hold_served;
   int hold_left;
   int quiet_cycles;
   int mismatch_count;
   int requests_sent;
   int results_checked;
   int saturated_count;

   earliest_free_worker_scheduler_unit #(
      .MAX_WORKERS(MAX_WORKERS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_task_duration   (req_task_duration),
      .req_new_batch       (req_new_batch),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_assigned_worker (rsp_assigned_worker),
      .rsp_start_time      (rsp_start_time),
      .rsp_finish_time     (rsp_finish_time),
      .rsp_makespan        (rsp_makespan)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // greedy assignment to the earliest free worker, lowest index on ties
   function automatic assignment_type schedule_task(logic [DUR_W-1:0] duration,
                                                    logic new_batch);
      int                pool;
      int                best;
      logic [TIME_W:0]   sum;
      assignment_type    decision;
      if (new_batch) begin
         foreach (worker_free_at[i]) worker_free_at[i] = '0;
         batch_span = '0;
      end
      pool = int'(pool_setting);
      if (pool < 1) pool = 1;
      if (pool > MAX_WORKERS) pool = MAX_WORKERS;
      best = 0;
      for (int i = 1; i < pool; i++) begin
         if (worker_free_at[i] < worker_free_at[best]) best = i;
      end
      sum = {1'b0, worker_free_at[best]} + {{(TIME_W - DUR_W + 1){1'b0}}, duration};
      decision.start  = worker_free_at[best];
      decision.finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      worker_free_at[best] = decision.finish;
      if (decision.finish > batch_span) batch_span = decision.finish;
      decision.worker   = WID_W'(best);
      decision.makespan = batch_span;
      return decision;
   endfunction

   // durations biased toward ties and extremes
   function automatic logic [DUR_W-1:0] random_duration();
      case ($urandom_range(9))
         0, 1, 2: return DUR_W'($urandom_range(7));
         3:       return $urandom_range(1) ? '1 : '0;
         default: return DUR_W'($urandom);
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] random_pool_size();
      case ($urandom_range(7))
         0:       return 5'd0;
         1:       return 5'd1;
         2:       return 5'd16;
         3:       return 5'd31;
         4:       return CFG_W'($urandom_range(31, 17));
         5:       return CFG_W'($urandom_range(4, 2));
         default: return CFG_W'($urandom_range(31));
      endcase
   endfunction

   // offer one task beat, called and returning at a falling edge
   task automatic send_task(logic [DUR_W-1:0] duration, logic new_batch);
      assignment_type decision;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_task_duration <= duration;
      req_new_batch     <= new_batch;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      decision = schedule_task(duration, new_batch);
      pending_assignments.insert(pending_assignments.size(), decision);
      requests_sent++;
      @(negedge clock);
   endtask

   // let every outstanding result drain, then write workers_in_use
   task automatic write_pool_size(logic [CFG_W-1:0] setting);
      req_valid <= 1'b0;
      while (pending_assignments.size() != 0) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(negedge clock);
      pool_setting      = setting;
      csr_write_enable <= 1'b0;
   endtask

   // receiver: random stall, or a long hold when asked
   initial begin
      rsp_stall   = 1'b0;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   // result check against the oldest expected assignment
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_assignments.size() == 0) begin
            $error("result beat with no task outstanding: worker %0d start %0d",
                   rsp_assigned_worker, rsp_start_time);
            mismatch_count++;
         end else begin
            oldest = pending_assignments.pop_front();
            results_checked++;
            if (oldest.finish == TIME_MAX) saturated_count++;
            if (rsp_assigned_worker !== oldest.worker) begin
               $error("assigned_worker: expected %0d, got %0d",
                      oldest.worker, rsp_assigned_worker);
               mismatch_count++;
            end
            if (rsp_start_time !== oldest.start) begin
               $error("start_time: expected %0d, got %0d", oldest.start, rsp_start_time);
               mismatch_count++;
            end
            if (rsp_finish_time !== oldest.finish) begin
               $error("finish_time: expected %0d, got %0d",
                      oldest.finish, rsp_finish_time);
               mismatch_count++;
            end
            if (rsp_makespan !== oldest.makespan) begin
               $error("makespan: expected %0d, got %0d", oldest.makespan, rsp_makespan);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("no beat for %0d cycles", IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      req_valid         = 1'b0;
      req_task_duration = '0;
      req_new_batch     = 1'b0;
      quiet_cycles      = 0;
      mismatch_count    = 0;
      requests_sent     = 0;
      results_checked   = 0;
      saturated_count   = 0;
      hold_requests     = 0;
      sender_idle_pct   = 15;
      receiver_idle_pct = 63;
      foreach (worker_free_at[i]) worker_free_at[i] = '0;
      batch_span   = '0;
      pool_setting = CFG_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED_TABLE[r].kind == ROW_SETTING) begin
            write_pool_size(DIRECTED_TABLE[r].setting);
         end else begin
            send_task(DIRECTED_TABLE[r].duration, DIRECTED_TABLE[r].new_batch);
            if (DIRECTED_TABLE[r].typed) pending_assignments[$] = DIRECTED_TABLE[r].result;
         end
      end

      // random chunks in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = (phase == 0) ? 15 : (phase == 1) ? 63 : 0;
         receiver_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 15 : 0;
         for (int chunk = 0; chunk < 6; chunk++) begin
            write_pool_size(random_pool_size());
            // receiver holds off while tasks keep coming
            if (phase == 2 && chunk == 0) hold_requests++;
            for (int k = 0; k < 85; k++) begin
               send_task(random_duration(),
                         (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(29) == 0));
            end
         end
      end

      // one worker, long tasks, run the free time into saturation
      write_pool_size(5'd1);
      for (int k = 0; k < 300; k++) begin
         send_task(DUR_W'($urandom_range(24'hFFFFFF, 24'hF00000)), k == 0);
      end

      req_valid <= 1'b0;
      while (pending_assignments.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("%0d task beats sent, %0d results checked, %0d finish times saturated",
               requests_sent, results_checked, saturated_count);
      $display("worker counts 0 to 31 incl. clamped values, batch clears, pool changes");
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
